// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is asserted
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2cq check failed");

// concurrent check that also holds across reset
`define CHK_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2cq reset check failed");

`endif

// ----- rtl/i2cq_pkg.sv -----
// i2cq_pkg: beat types, operation, bus command and job phase codes
// used by the i2c job queue rtl and its checker; no dependencies
package i2cq_pkg;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] data_byte;
    logic       data_last;
    logic [4:0] read_length;
    logic [7:0] flag_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] bus_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       read_done;
    logic [7:0] done_mask;
    logic [3:0] job_status;
    logic       enqueue_dropped;
  } out_item_t;

  // operation codes
  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_ENQ_RD  = 3'd1;
  localparam logic [2:0] OP_POLL    = 3'd2;
  localparam logic [2:0] OP_STEP    = 3'd3;
  localparam logic [2:0] OP_TIMEOUT = 3'd4;

  // bus commands
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_WRITE     = 3'd3;
  localparam logic [2:0] CMD_READ_ACK  = 3'd4;
  localparam logic [2:0] CMD_READ_NACK = 3'd5;

  // job phases
  localparam logic [3:0] PH_EMPTY      = 4'd0;
  localparam logic [3:0] PH_PENDING    = 4'd1;
  localparam logic [3:0] PH_START      = 4'd2;
  localparam logic [3:0] PH_ADDR       = 4'd3;
  localparam logic [3:0] PH_REG        = 4'd4;
  localparam logic [3:0] PH_RESTART    = 4'd5;
  localparam logic [3:0] PH_ADDR_RD    = 4'd6;
  localparam logic [3:0] PH_READ       = 4'd7;
  localparam logic [3:0] PH_LAST_READ  = 4'd8;
  localparam logic [3:0] PH_WRITE      = 4'd9;
  localparam logic [3:0] PH_LAST_WRITE = 4'd10;
  localparam logic [3:0] PH_DONE       = 4'd11;
  localparam logic [3:0] PH_TIMEOUT    = 4'd12;

  // longest read job
  localparam logic [4:0] MAX_READ = 5'd16;

endpackage

// ----- rtl/i2cq_ram.sv -----
// i2cq_ram: generic one-write, one-read ram with registered read data
// no dependencies
module i2cq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/i2cq_seq.sv -----
// i2cq_seq: job ring state, job and payload rams, single-pass step logic
// depends on i2cq_pkg and i2cq_ram
module i2cq_seq #(
  parameter int QUEUE_DEPTH   = 8,
  parameter int PAYLOAD_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  i2cq_pkg::in_item_t   item,
  output i2cq_pkg::out_item_t  result
);

  import i2cq_pkg::*;

  localparam int IW      = $clog2(QUEUE_DEPTH);
  localparam int CNTW    = $clog2(QUEUE_DEPTH + 1);
  localparam int BW      = $clog2(PAYLOAD_BYTES + 1);
  localparam int CW      = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int LEN_MAX = (PAYLOAD_BYTES > 16) ? PAYLOAD_BYTES : 16;
  localparam int LW      = $clog2(LEN_MAX + 1);
  localparam int JW      = LW + 24;
  localparam int PDEPTH  = QUEUE_DEPTH * PAYLOAD_BYTES;
  localparam int PAW     = $clog2(PDEPTH);

  // ring pointers, committed job count, head build count
  logic [IW-1:0]   head_r, head_nxt;
  logic [IW-1:0]   tail_r, tail_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [BW-1:0]   build_r, build_nxt;
  // tail job phase and progress
  logic [3:0]      tphase_r, tphase_nxt;
  logic [LW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   cur_r, cur_nxt;

  logic [3:0]      ph_mid;
  logic            full;
  logic            do_send;
  logic            do_read;
  logic [4:0]      rlen;

  logic            job_we;
  logic [JW-1:0]   job_wdata;
  logic [IW-1:0]   job_raddr;
  logic [JW-1:0]   job_q;
  logic            pay_we;
  logic [PAW-1:0]  pay_waddr;
  logic [PAW-1:0]  pay_raddr;
  logic [7:0]      pay_q;

  logic            j_is_read;
  logic [6:0]      j_slave;
  logic [7:0]      j_reg;
  logic [7:0]      j_mask;
  logic [LW-1:0]   j_len;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    next_slot = (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  assign j_is_read = job_q[JW-1];
  assign j_slave   = job_q[JW-2 -: 7];
  assign j_reg     = job_q[JW-9 -: 8];
  assign j_mask    = job_q[LW+7 -: 8];
  assign j_len     = job_q[LW-1:0];

  assign full = (count_r == CNTW'(QUEUE_DEPTH));

  always_comb begin
    if (item.read_length == 5'd0) begin
      rlen = 5'd1;
    end else if (item.read_length > MAX_READ) begin
      rlen = MAX_READ;
    end else begin
      rlen = item.read_length;
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    build_nxt  = build_r;
    tphase_nxt = tphase_r;
    rem_nxt    = rem_r;
    cur_nxt    = cur_r;
    ph_mid     = tphase_r;
    do_send    = 1'b0;
    do_read    = 1'b0;
    job_we     = 1'b0;
    job_wdata  = '0;
    pay_we     = 1'b0;
    pay_waddr  = PAW'(head_r) * PAW'(PAYLOAD_BYTES) + PAW'(build_r);
    result     = '0;

    unique case (item.operation)
      OP_APPEND: begin
        if (full) begin
          result.enqueue_dropped = 1'b1;
        end else begin
          if (build_r < BW'(PAYLOAD_BYTES)) begin
            pay_we    = 1'b1;
            build_nxt = build_r + BW'(1);
          end
          if (item.data_last) begin
            job_we    = 1'b1;
            job_wdata = {1'b0, item.slave_address, item.register_address, 8'h00,
                         LW'(build_nxt)};
            build_nxt = '0;
            head_nxt  = next_slot(head_r);
            count_nxt = count_r + CNTW'(1);
            if (count_r == '0) begin
              tphase_nxt = PH_PENDING;
            end
          end
        end
      end
      OP_ENQ_RD: begin
        if (full) begin
          result.enqueue_dropped = 1'b1;
        end else begin
          job_we    = 1'b1;
          job_wdata = {1'b1, item.slave_address, item.register_address, item.flag_mask,
                       LW'(rlen)};
          build_nxt = '0;
          head_nxt  = next_slot(head_r);
          count_nxt = count_r + CNTW'(1);
          if (count_r == '0) begin
            tphase_nxt = PH_PENDING;
          end
        end
      end
      OP_POLL: begin
        if (tphase_r == PH_DONE || tphase_r == PH_TIMEOUT) begin
          tail_nxt  = next_slot(tail_r);
          count_nxt = count_r - CNTW'(1);
          rem_nxt   = '0;
          cur_nxt   = '0;
          ph_mid    = (count_r > CNTW'(1)) ? PH_PENDING : PH_EMPTY;
        end
        tphase_nxt = ph_mid;
        if (ph_mid == PH_PENDING) begin
          result.bus_command = CMD_START;
          tphase_nxt         = PH_START;
        end
      end
      OP_STEP: begin
        unique case (tphase_r)
          PH_START: begin
            result.bus_command = CMD_WRITE;
            result.bus_byte    = {j_slave, 1'b0};
            tphase_nxt         = PH_ADDR;
            rem_nxt            = j_len;
            cur_nxt            = '0;
          end
          PH_ADDR: begin
            result.bus_command = CMD_WRITE;
            result.bus_byte    = j_reg;
            tphase_nxt         = PH_REG;
          end
          PH_REG: begin
            if (j_is_read) begin
              result.bus_command = CMD_START;
              tphase_nxt         = PH_RESTART;
            end else begin
              do_send = 1'b1;
            end
          end
          PH_RESTART: begin
            result.bus_command = CMD_WRITE;
            result.bus_byte    = {j_slave, 1'b1};
            tphase_nxt         = PH_ADDR_RD;
          end
          PH_ADDR_RD: begin
            do_read = 1'b1;
          end
          PH_READ: begin
            result.rx_valid = 1'b1;
            result.rx_byte  = item.data_byte;
            do_read         = 1'b1;
          end
          PH_LAST_READ: begin
            result.rx_valid    = 1'b1;
            result.rx_byte     = item.data_byte;
            result.read_done   = 1'b1;
            result.done_mask   = j_mask;
            result.bus_command = CMD_STOP;
            tphase_nxt         = PH_DONE;
          end
          PH_WRITE: begin
            do_send = 1'b1;
          end
          PH_LAST_WRITE: begin
            result.bus_command = CMD_STOP;
            tphase_nxt         = PH_DONE;
          end
          default: begin
          end
        endcase
      end
      OP_TIMEOUT: begin
        if (tphase_r >= PH_START && tphase_r <= PH_LAST_WRITE) begin
          tphase_nxt         = PH_TIMEOUT;
          result.bus_command = CMD_STOP;
        end
      end
      default: begin
      end
    endcase

    // next write byte in append order
    if (do_send) begin
      result.bus_command = CMD_WRITE;
      result.bus_byte    = pay_q;
      tphase_nxt         = (rem_r > LW'(1)) ? PH_WRITE : PH_LAST_WRITE;
      if (rem_r != '0) begin
        rem_nxt = rem_r - LW'(1);
      end
      if (cur_r < CW'(PAYLOAD_BYTES - 1)) begin
        cur_nxt = cur_r + CW'(1);
      end
    end

    // ack while more bytes follow, nack on the last one
    if (do_read) begin
      if (rem_r > LW'(1)) begin
        result.bus_command = CMD_READ_ACK;
        tphase_nxt         = PH_READ;
      end else begin
        result.bus_command = CMD_READ_NACK;
        tphase_nxt         = PH_LAST_READ;
      end
      if (rem_r != '0) begin
        rem_nxt = rem_r - LW'(1);
      end
    end

    result.job_status = tphase_nxt;
  end

  // rams are read every cycle at the tail after this step, so the data is
  // ready for the next beat; a job word is never needed in the beat right
  // after it was written (a poll must come first)
  always_comb begin
    if (step) begin
      job_raddr = tail_nxt;
      pay_raddr = PAW'(tail_nxt) * PAW'(PAYLOAD_BYTES) + PAW'(cur_nxt);
    end else begin
      job_raddr = tail_r;
      pay_raddr = PAW'(tail_r) * PAW'(PAYLOAD_BYTES) + PAW'(cur_r);
    end
  end

  i2cq_ram #(
    .WIDTH (JW),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_ram (
    .clk   (clk),
    .we    (step && job_we),
    .waddr (head_r),
    .wdata (job_wdata),
    .raddr (job_raddr),
    .rdata (job_q)
  );

  i2cq_ram #(
    .WIDTH (8),
    .DEPTH (PDEPTH)
  ) u_pay_ram (
    .clk   (clk),
    .we    (step && pay_we),
    .waddr (pay_waddr),
    .wdata (item.data_byte),
    .raddr (pay_raddr),
    .rdata (pay_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      build_r  <= '0;
      tphase_r <= PH_EMPTY;
      rem_r    <= '0;
      cur_r    <= '0;
    end else if (step) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      build_r  <= build_nxt;
      tphase_r <= tphase_nxt;
      rem_r    <= rem_nxt;
      cur_r    <= cur_nxt;
    end
  end

endmodule

// ----- rtl/i2c_master_transaction_queue.sv -----
// i2c_master_transaction_queue: top level, input register, result register
// depends on i2cq_pkg and i2cq_seq (which holds the rams)
//
// usage
// - in_*: one beat per operation (append write byte, enqueue read, poll,
//   bus step complete, timeout); every accepted beat gives exactly one
//   result beat on out_*, in order
// - out_data carries the bus command and byte to issue next, any received
//   byte, the read-done flag and mask, the tail job status and the drop flag
// - the result beat goes through the input register, then the step logic into
//   the result register; throughput is one beat per cycle while the result
//   register is free or drained by out_ready, set by the single-pass step
//   logic and the per-cycle read of the job and payload rams at the tail slot
// - stall: while out_ready is low the result register holds its beat and
//   one more beat waits in the input register; in_ready then drops
// - reset (rst_n low, synchronous): ring empty, pointers and counters zero,
//   both beat registers empty; ram contents are not cleared and need no
//   clearing pass, since every entry is written before it is used
module i2c_master_transaction_queue #(
  parameter int QUEUE_DEPTH   = 8,
  parameter int PAYLOAD_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cq_pkg::out_item_t out_data
);

  import i2cq_pkg::*;

  // input register stage
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  // result register stage
  logic      out_valid_r;
  out_item_t out_data_r;

  out_item_t step_result;
  logic      fire;

  // the step runs when the result register is free or being drained
  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  i2cq_seq #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .item   (s1_item_r),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // input beat capture
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      // result beat hand-off
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (fire) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/i2cq_checker.sv -----
// i2cq_checker: port-level checks on the i2c job queue, bound to the top
// depends on i2cq_pkg and assert_macros.svh
`include "assert_macros.svh"

module i2cq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input i2cq_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input i2cq_pkg::out_item_t out_data
);

  import i2cq_pkg::*;

  // a stalled result beat holds
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // finishing a read job delivers its last byte and a stop into done
  `CHK_ASSERT(a_done_stop, clk, rst_n, out_valid && out_data.read_done |-> out_data.rx_valid && (out_data.bus_command == CMD_STOP) && (out_data.job_status == PH_DONE))

  // a received byte only comes with a read command or the closing stop
  `CHK_ASSERT(a_rx_cmd, clk, rst_n, out_valid && out_data.rx_valid |-> (out_data.bus_command == CMD_READ_ACK) || (out_data.bus_command == CMD_READ_NACK) || (out_data.bus_command == CMD_STOP))

  // a dropped enqueue touches nothing on the bus
  `CHK_ASSERT(a_drop_quiet, clk, rst_n, out_valid && out_data.enqueue_dropped |-> (out_data.bus_command == CMD_NONE) && !out_data.rx_valid && !out_data.read_done)

  // no result beat right after reset
  `CHK_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid)

endmodule

bind i2c_master_transaction_queue i2cq_checker u_i2cq_checker (.*);

// ----- tb/tb_i2c_master_transaction_queue.sv -----
// self-checking testbench for the i2c master job queue: directed rows, then random job traffic
// depends on i2cq_pkg and the i2c_master_transaction_queue rtl; no files or arguments read
module tb_i2c_master_transaction_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cq_pkg::*;

  localparam int QUEUE_DEPTH   = 8;
  localparam int PAYLOAD_BYTES = 16;
  // beats of real work to send before the run winds down
  localparam int ITEMS         = 800;

  // operation codes the block must ignore
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam out_item_t NO_PIN = '0;

  typedef logic [$clog2(QUEUE_DEPTH)-1:0] slot_t;

  // one row of the directed part: a beat, how often to send it, and an
  // optional hand-written result that replaces the predicted one
  typedef struct packed {
    in_item_t   beat;
    logic [3:0] reps;
    logic       pinned;
    out_item_t  result;
  } vector_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // predictor copy of the job ring
  logic [3:0] slot_phase   [QUEUE_DEPTH];
  logic       slot_is_read [QUEUE_DEPTH];
  logic [6:0] slot_slave   [QUEUE_DEPTH];
  logic [7:0] slot_reg     [QUEUE_DEPTH];
  logic [4:0] slot_left    [QUEUE_DEPTH];
  logic [7:0] slot_mask    [QUEUE_DEPTH];
  logic [3:0] slot_cursor  [QUEUE_DEPTH];
  logic [7:0] slot_bytes   [QUEUE_DEPTH][PAYLOAD_BYTES];
  slot_t      head_ptr;
  slot_t      tail_ptr;

  out_item_t   expected_results[$];
  vector_row_t directed_rows[$];
  out_item_t   want;

  int  errors;
  int  beats_sent;
  int  beats_checked;
  int  reads_finished;
  int  stops_seen;
  int  drops_seen;
  bit  in_quiet;
  bit  out_quiet;

  i2c_master_transaction_queue #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // next payload byte of a write job; bytes leave in append order
  function automatic logic [7:0] next_payload_byte(input slot_t t);
    logic [7:0] tx;
    tx = slot_bytes[t][slot_cursor[t]];
    slot_phase[t] = (slot_left[t] > 5'd1) ? PH_WRITE : PH_LAST_WRITE;
    if (slot_left[t] > 5'd0) slot_left[t] = slot_left[t] - 5'd1;
    if (slot_cursor[t] < PAYLOAD_BYTES - 1) slot_cursor[t] = slot_cursor[t] + 4'd1;
    return tx;
  endfunction

  // ack while more bytes follow, nack on the last one
  function automatic logic [2:0] request_read(input slot_t t);
    logic [2:0] cmd;
    if (slot_left[t] > 5'd1) begin
      cmd = CMD_READ_ACK;
      slot_phase[t] = PH_READ;
    end else begin
      cmd = CMD_READ_NACK;
      slot_phase[t] = PH_LAST_READ;
    end
    if (slot_left[t] > 5'd0) slot_left[t] = slot_left[t] - 5'd1;
    return cmd;
  endfunction

  // applies one accepted beat to the predicted ring, returns the result beat
  function automatic out_item_t advance_job_queue(input in_item_t b);
    out_item_t  r;
    slot_t      h;
    slot_t      t;
    logic [4:0] len;
    r = '0;
    h = head_ptr;
    t = tail_ptr;
    case (b.operation)
      OP_APPEND, OP_ENQ_RD: begin
        if (slot_phase[h] != PH_EMPTY) begin
          // ring full, beat dropped
          r.enqueue_dropped = 1'b1;
        end else if (b.operation == OP_APPEND) begin
          // bytes past the payload size are lost, the count stops there
          if (slot_left[h] < PAYLOAD_BYTES) begin
            slot_bytes[h][slot_left[h]] = b.data_byte;
            slot_left[h] = slot_left[h] + 5'd1;
          end
          if (b.data_last) begin
            slot_is_read[h] = 1'b0;
            slot_slave[h]   = b.slave_address;
            slot_reg[h]     = b.register_address;
            slot_mask[h]    = 8'h00;
            slot_cursor[h]  = 4'd0;
            slot_phase[h]   = PH_PENDING;
            head_ptr        = h + 1'b1;
          end
        end else begin
          // a read replaces any half-built write at the head
          len = b.read_length;
          if (len == 5'd0) len = 5'd1;
          if (len > MAX_READ) len = MAX_READ;
          slot_is_read[h] = 1'b1;
          slot_slave[h]   = b.slave_address;
          slot_reg[h]     = b.register_address;
          slot_left[h]    = len;
          slot_mask[h]    = b.flag_mask;
          slot_cursor[h]  = 4'd0;
          slot_phase[h]   = PH_PENDING;
          head_ptr        = h + 1'b1;
        end
      end
      OP_POLL: begin
        // retire a finished or timed-out tail job, then start the next one
        if (slot_phase[t] == PH_DONE || slot_phase[t] == PH_TIMEOUT) begin
          slot_phase[t]  = PH_EMPTY;
          slot_left[t]   = 5'd0;
          slot_cursor[t] = 4'd0;
          t = t + 1'b1;
          tail_ptr = t;
        end
        if (slot_phase[t] == PH_PENDING) begin
          r.bus_command = CMD_START;
          slot_phase[t] = PH_START;
        end
      end
      OP_STEP: begin
        case (slot_phase[t])
          PH_START: begin
            r.bus_command = CMD_WRITE;
            r.bus_byte    = {slot_slave[t], 1'b0};
            slot_phase[t] = PH_ADDR;
          end
          PH_ADDR: begin
            r.bus_command = CMD_WRITE;
            r.bus_byte    = slot_reg[t];
            slot_phase[t] = PH_REG;
          end
          PH_REG: begin
            if (slot_is_read[t]) begin
              r.bus_command = CMD_START;
              slot_phase[t] = PH_RESTART;
            end else begin
              r.bus_command = CMD_WRITE;
              r.bus_byte    = next_payload_byte(t);
            end
          end
          PH_RESTART: begin
            r.bus_command = CMD_WRITE;
            r.bus_byte    = {slot_slave[t], 1'b1};
            slot_phase[t] = PH_ADDR_RD;
          end
          PH_ADDR_RD: begin
            r.bus_command = request_read(t);
          end
          PH_READ: begin
            r.rx_valid    = 1'b1;
            r.rx_byte     = b.data_byte;
            r.bus_command = request_read(t);
          end
          PH_LAST_READ: begin
            r.rx_valid    = 1'b1;
            r.rx_byte     = b.data_byte;
            r.read_done   = 1'b1;
            r.done_mask   = slot_mask[t];
            r.bus_command = CMD_STOP;
            slot_phase[t] = PH_DONE;
          end
          PH_WRITE: begin
            r.bus_command = CMD_WRITE;
            r.bus_byte    = next_payload_byte(t);
          end
          PH_LAST_WRITE: begin
            r.bus_command = CMD_STOP;
            slot_phase[t] = PH_DONE;
          end
          default: begin
          end
        endcase
      end
      OP_TIMEOUT: begin
        // only an active job can time out
        if (slot_phase[t] >= PH_START && slot_phase[t] <= PH_LAST_WRITE) begin
          slot_phase[t] = PH_TIMEOUT;
          r.bus_command = CMD_STOP;
        end
      end
      default: begin
      end
    endcase
    r.job_status = slot_phase[tail_ptr];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // beat builders
  // ---------------------------------------------------------------------

  function automatic in_item_t mk_beat(input logic [2:0] op, input logic [6:0] sla,
                                       input logic [7:0] rg, input logic [7:0] data,
                                       input logic last, input logic [4:0] len,
                                       input logic [7:0] mask);
    in_item_t b;
    b.operation        = op;
    b.slave_address    = sla;
    b.register_address = rg;
    b.data_byte        = data;
    b.data_last        = last;
    b.read_length      = len;
    b.flag_mask        = mask;
    return b;
  endfunction

  function automatic out_item_t mk_result(input logic [2:0] cmd, input logic [7:0] tx,
                                          input logic rxv, input logic [7:0] rxb,
                                          input logic rdone, input logic [7:0] dmask,
                                          input logic [3:0] status, input logic drop);
    out_item_t r;
    r.bus_command     = cmd;
    r.bus_byte        = tx;
    r.rx_valid        = rxv;
    r.rx_byte         = rxb;
    r.read_done       = rdone;
    r.done_mask       = dmask;
    r.job_status      = status;
    r.enqueue_dropped = drop;
    return r;
  endfunction

  function automatic void add_row(input in_item_t b, input int reps, input logic pinned,
                                  input out_item_t res);
    vector_row_t row;
    row.beat   = b;
    row.reps   = reps[3:0];
    row.pinned = pinned;
    row.result = res;
    directed_rows.push_back(row);
  endfunction

  // every field random, operation given
  function automatic in_item_t rand_beat(input logic [2:0] op);
    in_item_t b;
    b.operation        = op;
    b.slave_address    = $urandom_range(0, 127);
    b.register_address = $urandom_range(0, 255);
    b.data_byte        = $urandom_range(0, 255);
    b.data_last        = $urandom_range(0, 1);
    b.read_length      = $urandom_range(0, 31);
    b.flag_mask        = $urandom_range(0, 255);
    return b;
  endfunction

  // read enqueue, mostly short, sometimes at or beyond the length limits
  function automatic in_item_t read_job_beat();
    in_item_t b;
    b = rand_beat(OP_ENQ_RD);
    case ($urandom_range(0, 9))
      0: b.read_length = 5'd0;
      1: b.read_length = $urandom_range(17, 31);
      2: b.read_length = MAX_READ;
      default: b.read_length = $urandom_range(1, 4);
    endcase
    return b;
  endfunction

  // ---------------------------------------------------------------------
  // input side: random gap, then hold the beat until the block takes it
  // ---------------------------------------------------------------------
  task automatic send_op(input in_item_t b, input logic pinned, input out_item_t pin_res);
    int        gap;
    out_item_t predicted;
    // occasionally flip into or out of a back-to-back stretch
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // beat taken at this edge: the predictor moves in lockstep
    predicted = advance_job_queue(b);
    expected_results.push_back(pinned ? pin_res : predicted);
    if (b.operation <= OP_TIMEOUT) beats_sent++;
  endtask

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    in_item_t b;
    int       pick;
    int       n;
    int       guard;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    errors     = 0;
    beats_sent = 0;
    in_quiet   = 1'b0;

    // predicted ring after reset
    for (int s = 0; s < QUEUE_DEPTH; s++) begin
      slot_phase[s]   = PH_EMPTY;
      slot_is_read[s] = 1'b0;
      slot_slave[s]   = '0;
      slot_reg[s]     = '0;
      slot_left[s]    = '0;
      slot_mask[s]    = '0;
      slot_cursor[s]  = '0;
      for (int p = 0; p < PAYLOAD_BYTES; p++) slot_bytes[s][p] = '0;
    end
    head_ptr = '0;
    tail_ptr = '0;

    // directed rows: op, slave, reg, data, last, length, mask
    // empty ring: poll and an unused code do nothing
    add_row(mk_beat(OP_POLL, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1, NO_PIN);
    add_row(mk_beat(OP_UNUSED_HI, 7'h7F, 8'hFF, 8'hFF, 1'b1, 5'd31, 8'hFF), 1, 1'b1, NO_PIN);
    // one-byte read at the top address, zero length taken as one
    add_row(mk_beat(OP_ENQ_RD, 7'h7F, 8'hFF, 8'h00, 1'b0, 5'd0, 8'hFF), 1, 1'b1,
            mk_result(CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, PH_PENDING, 1'b0));
    add_row(mk_beat(OP_POLL, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1,
            mk_result(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, PH_START, 1'b0));
    add_row(mk_beat(OP_STEP, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1,
            mk_result(CMD_WRITE, 8'hFE, 1'b0, 8'h00, 1'b0, 8'h00, PH_ADDR, 1'b0));
    add_row(mk_beat(OP_STEP, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1,
            mk_result(CMD_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, PH_REG, 1'b0));
    add_row(mk_beat(OP_STEP, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1,
            mk_result(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, PH_RESTART, 1'b0));
    add_row(mk_beat(OP_STEP, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1,
            mk_result(CMD_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, PH_ADDR_RD, 1'b0));
    add_row(mk_beat(OP_STEP, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1,
            mk_result(CMD_READ_NACK, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, PH_LAST_READ, 1'b0));
    add_row(mk_beat(OP_STEP, 7'h00, 8'h00, 8'hA5, 1'b0, 5'd0, 8'h00), 1, 1'b1,
            mk_result(CMD_STOP, 8'h00, 1'b1, 8'hA5, 1'b1, 8'hFF, PH_DONE, 1'b0));
    // retire; the next slot is empty
    add_row(mk_beat(OP_POLL, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1, NO_PIN);
    // two-byte write to address zero, cut short by a timeout
    add_row(mk_beat(OP_APPEND, 7'h7F, 8'hFF, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b0, NO_PIN);
    add_row(mk_beat(OP_APPEND, 7'h00, 8'h00, 8'hFF, 1'b1, 5'd0, 8'h00), 1, 1'b0, NO_PIN);
    add_row(mk_beat(OP_POLL, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b0, NO_PIN);
    add_row(mk_beat(OP_STEP, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 3, 1'b0, NO_PIN);
    add_row(mk_beat(OP_TIMEOUT, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1,
            mk_result(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, PH_TIMEOUT, 1'b0));
    add_row(mk_beat(OP_POLL, 7'h00, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00), 1, 1'b1, NO_PIN);
    // half-built write replaced by a read, then fill the ring
    add_row(mk_beat(OP_APPEND, 7'h2A, 8'h55, 8'h3C, 1'b0, 5'd0, 8'h00), 1, 1'b0, NO_PIN);
    add_row(mk_beat(OP_ENQ_RD, 7'h15, 8'hAA, 8'h00, 1'b0, 5'd31, 8'h00), 1, 1'b0, NO_PIN);
    add_row(mk_beat(OP_ENQ_RD, 7'h40, 8'h01, 8'h00, 1'b0, MAX_READ, 8'h80), 7, 1'b0, NO_PIN);
    // full ring: both kinds of enqueue are dropped
    add_row(mk_beat(OP_ENQ_RD, 7'h01, 8'h02, 8'h00, 1'b0, 5'd2, 8'h01), 1, 1'b1,
            mk_result(CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, PH_PENDING, 1'b1));
    add_row(mk_beat(OP_APPEND, 7'h01, 8'h02, 8'h77, 1'b1, 5'd0, 8'h00), 1, 1'b1,
            mk_result(CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, PH_PENDING, 1'b1));

    // synchronous reset, applied once at the start
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_op(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].result);
      end
    end

    // random part: mostly well-formed jobs and bus servicing, some noise
    while (beats_sent < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // write job, now and then long enough to overflow the payload
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
          b = rand_beat(OP_APPEND);
          // a few builds are left open and later continued or replaced
          b.data_last = (k == n - 1) && ($urandom_range(0, 19) != 0);
          send_op(b, 1'b0, NO_PIN);
        end
      end else if (pick < 48) begin
        send_op(read_job_beat(), 1'b0, NO_PIN);
      end else if (pick < 90) begin
        // poll, then walk the tail job through the bus until it finishes
        send_op(rand_beat(OP_POLL), 1'b0, NO_PIN);
        guard = 0;
        while (slot_phase[tail_ptr] >= PH_START && slot_phase[tail_ptr] <= PH_LAST_WRITE
               && guard < 40) begin
          pick = $urandom_range(0, 99);
          if (pick < 3) begin
            send_op(rand_beat(OP_TIMEOUT), 1'b0, NO_PIN);
          end else if (pick < 8) begin
            // software keeps queueing while the bus is busy
            send_op(read_job_beat(), 1'b0, NO_PIN);
          end else begin
            send_op(rand_beat(OP_STEP), 1'b0, NO_PIN);
          end
          guard++;
        end
      end else begin
        // noise: any code, unused ones included
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          send_op(rand_beat($urandom_range(0, 7)), 1'b0, NO_PIN);
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then a margin well past the input and result registers
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d beats of job traffic, checked %0d result beats, %0d mismatches",
             beats_sent, beats_checked, errors);
    $display("read jobs finished %0d, stops issued %0d, enqueues dropped on a full ring %0d",
             reads_finished, stops_seen, drops_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // result side: random stall before each beat, then wait for one
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    out_quiet = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // checker: every result beat against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = expected_results.pop_front();
        beats_checked++;
        if (out_data.bus_command !== want.bus_command) begin
          $error("bus_command: expected %0d, got %0d", want.bus_command, out_data.bus_command);
          errors++;
        end
        if (out_data.bus_byte !== want.bus_byte) begin
          $error("bus_byte: expected %0h, got %0h", want.bus_byte, out_data.bus_byte);
          errors++;
        end
        if (out_data.rx_valid !== want.rx_valid) begin
          $error("rx_valid: expected %0d, got %0d", want.rx_valid, out_data.rx_valid);
          errors++;
        end
        if (out_data.rx_byte !== want.rx_byte) begin
          $error("rx_byte: expected %0h, got %0h", want.rx_byte, out_data.rx_byte);
          errors++;
        end
        if (out_data.read_done !== want.read_done) begin
          $error("read_done: expected %0d, got %0d", want.read_done, out_data.read_done);
          errors++;
        end
        if (out_data.done_mask !== want.done_mask) begin
          $error("done_mask: expected %0h, got %0h", want.done_mask, out_data.done_mask);
          errors++;
        end
        if (out_data.job_status !== want.job_status) begin
          $error("job_status: expected %0d, got %0d", want.job_status, out_data.job_status);
          errors++;
        end
        if (out_data.enqueue_dropped !== want.enqueue_dropped) begin
          $error("enqueue_dropped: expected %0d, got %0d",
                 want.enqueue_dropped, out_data.enqueue_dropped);
          errors++;
        end
        if (want.read_done) reads_finished++;
        if (want.bus_command == CMD_STOP) stops_seen++;
        if (want.enqueue_dropped) drops_seen++;
      end
    end
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $error("run did not finish, %0d results still expected", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
